[rtl/core/tlfp_pkg.sv]
package tlfp_pkg;

    // Parser phases of one tags-file line.
    typedef enum logic [3:0] {
        PH_TAG,
        PH_FILE,
        PH_ADDR,
        PH_NUM,
        PH_PAT,
        PH_DELIM,
        PH_DSEMI,
        PH_SEMI,
        PH_AFTER,
        PH_NAME,
        PH_VALUE
    } tlfp_phase_t;

    // Reasons for rejecting a line, kept inside the block.
    typedef enum logic [2:0] {
        RSN_NONE,
        RSN_TAG_CUT,
        RSN_FILE_CUT,
        RSN_BAD_ADDR,
        RSN_PAT_CUT,
        RSN_JUNK
    } tlfp_reason_t;

    // Characters the parser looks for.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // An event result carries this code.
    localparam logic [7:0] EV_CODE = 8'h00;

    // Progress of matching the attribute name against "file".
    localparam logic [2:0] MATCH_FULL = 3'd4;
    localparam logic [2:0] MATCH_NONE = 3'd7;

    // One queue entry: up to three results caused by one input byte.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] data;
    } tlfp_entry_t;

    // Letters of the attribute name "file".
    function automatic logic [7:0] file_letter(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0: ch = 8'h66;
            2'd1: ch = 8'h69;
            2'd2: ch = 8'h6C;
            2'd3: ch = 8'h65;
            default: ch = 8'h65;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/tlfp_front.sv]
module tlfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 push,
    output tlfp_pkg::tlfp_entry_t push_entry,
    input  logic                 full
);
    import tlfp_pkg::*;

    tlfp_phase_t  phase_reg, phase_next;
    tlfp_reason_t reason_reg, reason_next;
    logic         dq_reg, dq_next;
    logic         quote_reg, quote_next;
    logic         hb_reg, hb_next;
    logic [2:0]   ms_reg, ms_next;
    logic         ve_reg, ve_next;
    logic         skip_reg, skip_next;

    logic            accept;
    logic            eol, is_tab, is_digit, is_delim, is_close;
    logic            file_empty;
    logic [3:0][7:0] slot;
    logic [2:0]      cnt;

    // Byte classification.
    assign eol        = (in_byte == CH_LF) || (in_byte == CH_NUL);
    assign is_tab     = (in_byte == CH_TAB);
    assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_delim   = (in_byte == CH_SLASH) || (in_byte == CH_QMARK);
    assign is_close   = (in_byte == (dq_reg ? CH_QMARK : CH_SLASH));
    assign file_empty = ve_reg && (ms_reg == MATCH_FULL);

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    // Next state of the parser.
    always_comb
    begin
        phase_next  = phase_reg;
        reason_next = reason_reg;
        dq_next     = dq_reg;
        quote_next  = quote_reg;
        hb_next     = hb_reg;
        ms_next     = ms_reg;
        ve_next     = ve_reg;
        skip_next   = skip_reg;
        if (skip_reg)
        begin
            if (eol)
            begin
                phase_next = PH_TAG;
                dq_next    = 1'b0;
                quote_next = 1'b0;
                hb_next    = 1'b0;
                ms_next    = 3'd0;
                ve_next    = 1'b1;
                skip_next  = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_ADDR:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_NUM;
                    end
                    else if (is_delim)
                    begin
                        dq_next    = (in_byte == CH_QMARK);
                        quote_next = 1'b0;
                        phase_next = PH_PAT;
                    end
                    else
                    begin
                        reason_next = RSN_BAD_ADDR;
                        if (eol)
                        begin
                            phase_next = PH_TAG;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                end
                PH_NUM, PH_DELIM:
                begin
                    if (phase_reg == PH_DELIM && in_byte == CH_SEMI)
                    begin
                        phase_next = PH_DSEMI;
                    end
                    else if (phase_reg == PH_NUM && is_digit)
                    begin
                        phase_next = PH_NUM;
                    end
                    else if (eol)
                    begin
                        phase_next = PH_TAG;
                        dq_next    = 1'b0;
                        ve_next    = 1'b1;
                    end
                    else if (is_tab)
                    begin
                        phase_next = PH_NAME;
                        ms_next    = 3'd0;
                        ve_next    = 1'b1;
                        hb_next    = 1'b0;
                    end
                    else if (in_byte == CH_SEMI)
                    begin
                        phase_next = PH_SEMI;
                    end
                    else
                    begin
                        reason_next = RSN_JUNK;
                        skip_next   = 1'b1;
                    end
                end
                PH_PAT:
                begin
                    if (eol)
                    begin
                        reason_next = RSN_PAT_CUT;
                        phase_next  = PH_TAG;
                        dq_next     = 1'b0;
                        quote_next  = 1'b0;
                    end
                    else if (quote_reg)
                    begin
                        quote_next = 1'b0;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        quote_next = 1'b1;
                    end
                    else if (is_close)
                    begin
                        phase_next = PH_DELIM;
                    end
                end
                PH_DSEMI:
                begin
                    if (is_delim)
                    begin
                        dq_next    = (in_byte == CH_QMARK);
                        quote_next = 1'b0;
                        phase_next = PH_PAT;
                    end
                    else if (in_byte == CH_DQUOTE)
                    begin
                        phase_next = PH_AFTER;
                    end
                    else
                    begin
                        reason_next = RSN_JUNK;
                        if (eol)
                        begin
                            phase_next = PH_TAG;
                            dq_next    = 1'b0;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                end
                PH_SEMI:
                begin
                    if (in_byte == CH_DQUOTE)
                    begin
                        phase_next = PH_AFTER;
                    end
                    else
                    begin
                        reason_next = RSN_JUNK;
                        if (eol)
                        begin
                            phase_next = PH_TAG;
                            dq_next    = 1'b0;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                end
                PH_AFTER:
                begin
                    if (eol)
                    begin
                        phase_next = PH_TAG;
                        dq_next    = 1'b0;
                    end
                    else if (is_tab)
                    begin
                        phase_next = PH_NAME;
                        ms_next    = 3'd0;
                        ve_next    = 1'b1;
                        hb_next    = 1'b0;
                    end
                    else
                    begin
                        reason_next = RSN_JUNK;
                        skip_next   = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    if (eol)
                    begin
                        phase_next = PH_TAG;
                        dq_next    = 1'b0;
                        ms_next    = 3'd0;
                        ve_next    = 1'b1;
                    end
                    else if (is_tab)
                    begin
                        ms_next = 3'd0;
                        ve_next = 1'b1;
                    end
                    else if (in_byte == CH_COLON)
                    begin
                        phase_next = PH_VALUE;
                        ve_next    = 1'b1;
                        hb_next    = 1'b0;
                    end
                    else if (ms_reg < MATCH_FULL && in_byte == file_letter(ms_reg[1:0]))
                    begin
                        ms_next = ms_reg + 3'd1;
                    end
                    else
                    begin
                        ms_next = MATCH_NONE;
                    end
                end
                PH_VALUE:
                begin
                    hb_next = 1'b0;
                    if (hb_reg && (in_byte == CH_LOW_T || in_byte == CH_LOW_N
                                   || in_byte == CH_BSLASH))
                    begin
                        hb_next = 1'b0;
                    end
                    else if (eol)
                    begin
                        phase_next = PH_TAG;
                        dq_next    = 1'b0;
                        ms_next    = 3'd0;
                        ve_next    = 1'b1;
                    end
                    else if (is_tab)
                    begin
                        phase_next = PH_NAME;
                        ms_next    = 3'd0;
                        ve_next    = 1'b1;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        hb_next = 1'b1;
                        ve_next = 1'b0;
                    end
                    else
                    begin
                        ve_next = 1'b0;
                    end
                end
                default:
                begin
                    // Tag name, file name and any unused phase code.
                    if (eol)
                    begin
                        reason_next = (phase_reg == PH_FILE) ? RSN_FILE_CUT : RSN_TAG_CUT;
                        phase_next  = PH_TAG;
                        dq_next     = 1'b0;
                    end
                    else if (is_tab)
                    begin
                        phase_next = (phase_reg == PH_FILE) ? PH_ADDR : PH_FILE;
                    end
                    else if (phase_reg != PH_FILE)
                    begin
                        phase_next = PH_TAG;
                    end
                end
            endcase
        end
    end

    // Results caused by the byte, in order; the fourth is dropped.
    always_comb
    begin
        slot = '0;
        cnt  = 3'd0;
        if (!skip_reg)
        begin
            unique case (phase_reg)
                PH_ADDR:
                begin
                    slot[0] = (is_digit || is_delim) ? in_byte : EV_CODE;
                    cnt     = 3'd1;
                end
                PH_NUM, PH_DELIM:
                begin
                    if (phase_reg == PH_DELIM && in_byte == CH_SEMI)
                    begin
                        cnt = 3'd0;
                    end
                    else if (phase_reg == PH_NUM && is_digit)
                    begin
                        slot[0] = in_byte;
                        cnt     = 3'd1;
                    end
                    else
                    begin
                        // Field end, then line accept or reject unless a tab or ';'.
                        slot[0] = EV_CODE;
                        slot[1] = EV_CODE;
                        cnt     = (is_tab || in_byte == CH_SEMI) ? 3'd1 : 3'd2;
                    end
                end
                PH_PAT:
                begin
                    slot[0] = eol ? EV_CODE : in_byte;
                    cnt     = 3'd1;
                end
                PH_DSEMI:
                begin
                    if (is_delim)
                    begin
                        slot[0] = CH_SEMI;
                        slot[1] = in_byte;
                        cnt     = 3'd2;
                    end
                    else
                    begin
                        slot[0] = EV_CODE;
                        cnt     = 3'd1;
                    end
                end
                PH_SEMI:
                begin
                    slot[0] = EV_CODE;
                    cnt     = (in_byte == CH_DQUOTE) ? 3'd0 : 3'd1;
                end
                PH_AFTER:
                begin
                    slot[0] = EV_CODE;
                    cnt     = is_tab ? 3'd0 : 3'd1;
                end
                PH_NAME:
                begin
                    if (eol)
                    begin
                        slot[0] = EV_CODE;
                        slot[1] = EV_CODE;
                        cnt     = 3'd2;
                    end
                    else if (is_tab || in_byte == CH_COLON)
                    begin
                        slot[0] = EV_CODE;
                        cnt     = 3'd1;
                    end
                    else
                    begin
                        slot[0] = in_byte;
                        cnt     = 3'd1;
                    end
                end
                PH_VALUE:
                begin
                    if (hb_reg && (in_byte == CH_LOW_T || in_byte == CH_LOW_N
                                   || in_byte == CH_BSLASH))
                    begin
                        // Translated escape.
                        slot[0] = (in_byte == CH_LOW_T) ? CH_TAB :
                                  (in_byte == CH_LOW_N) ? CH_LF : CH_BSLASH;
                        cnt     = 3'd1;
                    end
                    else
                    begin
                        if (hb_reg)
                        begin
                            slot[cnt[1:0]] = CH_BSLASH;
                            cnt            = cnt + 3'd1;
                        end
                        if (eol || is_tab)
                        begin
                            if (file_empty)
                            begin
                                slot[cnt[1:0]] = EV_CODE;
                                cnt            = cnt + 3'd1;
                            end
                            slot[cnt[1:0]] = EV_CODE;
                            cnt            = cnt + 3'd1;
                            if (eol)
                            begin
                                slot[cnt[1:0]] = EV_CODE;
                                cnt            = cnt + 3'd1;
                            end
                        end
                        else if (in_byte != CH_BSLASH)
                        begin
                            slot[cnt[1:0]] = in_byte;
                            cnt            = cnt + 3'd1;
                        end
                    end
                end
                default:
                begin
                    slot[0] = (eol || is_tab) ? EV_CODE : in_byte;
                    cnt     = 3'd1;
                end
            endcase
        end
    end

    assign push             = accept && (cnt != 3'd0);
    assign push_entry.count = (cnt >= 3'd3) ? 2'd3 : cnt[1:0];
    assign push_entry.data  = slot[2:0];

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            reason_reg <= RSN_NONE;
            dq_reg     <= 1'b0;
            quote_reg  <= 1'b0;
            hb_reg     <= 1'b0;
            ms_reg     <= 3'd0;
            ve_reg     <= 1'b1;
            skip_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            reason_reg <= reason_next;
            dq_reg     <= dq_next;
            quote_reg  <= quote_next;
            hb_reg     <= hb_next;
            ms_reg     <= ms_next;
            ve_reg     <= ve_next;
            skip_reg   <= skip_next;
        end
    end

    // A line that is being skipped was rejected for a stated reason.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skip_reg) |-> reason_reg != RSN_NONE)
        else $error("line skipped without a reject reason");

    // Quoting is only live inside a pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        quote_reg |-> phase_reg == PH_PAT)
        else $error("pattern quote held outside a pattern");

    // A held backslash only exists within an attribute value.
    assert property (@(posedge clk) disable iff (!rst_n)
        hb_reg |-> phase_reg == PH_VALUE)
        else $error("backslash held outside an attribute value");

endmodule

[rtl/core/tlfp_queue.sv]
module tlfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tlfp_pkg::tlfp_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output tlfp_pkg::tlfp_entry_t head,
    output logic                  empty
);
    import tlfp_pkg::*;

    // DEPTH must be a power of two, at least 2, so the pointers wrap by themselves; the block does not check it.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlfp_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("entry written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("entry taken from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond its depth");

endmodule

[rtl/core/tlfp_back.sv]
module tlfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlfp_pkg::tlfp_entry_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte
);
    import tlfp_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       xfer;

    // Walk through the results of the head entry, one transfer per cycle while out_ready is high.
    assign out_valid = !empty;
    assign out_byte  = head.data[idx_reg];
    assign last      = (idx_reg == head.count - 2'd1);
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[rtl/core/tag_line_field_parser.sv]
// Tags-file line parser. One line byte is taken per transfer on s_axis; a
// line ends at byte 0x0A or 0x00. Each byte causes zero to three transfers
// on m_axis: a field character (after escape translation) or an event code
// of zero for field ends, kind values, empty file values, line accept and
// line reject. Bytes already delivered for a rejected line must be dropped
// downstream. The parser classifies a byte in the cycle it is accepted, so
// s_axis takes one byte per cycle as long as the result queue
// (QUEUE_DEPTH entries, one entry per byte that has results) has room.
// m_axis delivers one result per cycle while m_axis_tready is high; the
// output serialiser sets the sustained rate. A result is registered in
// the result queue when its byte is accepted and is offered on m_axis
// from the queue head.
module tag_line_field_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [7:0] out_byte
);
    import tlfp_pkg::*;

    tlfp_entry_t push_entry;
    tlfp_entry_t head;
    logic        push;
    logic        full;
    logic        pop;
    logic        empty;

    // Front: accepts and classifies line bytes.
    tlfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // Queue of result groups between the two sides.
    tlfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    // Back: sends the results one transfer at a time.
    tlfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata)
    );

endmodule

[sim/tag_line_field_parser_tb.sv]
`timescale 1ns / 1ps

module tag_line_field_parser_tb;

    import tlfp_pkg::*;

    localparam int RANDOM_ITEMS = 170;
    localparam int QUIET_AFTER  = 135;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] FILE_WORD [4] = '{8'h66, 8'h69, 8'h6C, 8'h65};
    localparam logic [7:0] KIND_WORD [4] = '{8'h6B, 8'h69, 8'h6E, 8'h64};

    // One directed row: the byte, and either a typed result (count 0 or 1)
    // or a count of -1 when the parser model supplies the results.
    typedef struct {
        logic [7:0] data;
        int         count;
        logic [7:0] result;
    } dir_row_t;

    typedef struct {
        int         count;
        logic [7:0] result;
    } byte_note_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte

    // State of the line parser model.
    tlfp_phase_t  lp_phase;
    tlfp_reason_t lp_reason;
    logic         lp_delim_is_q;
    logic         lp_quoted;
    logic         lp_held_bs;
    logic         lp_value_empty;
    logic         lp_skip;
    logic [2:0]   lp_file_step;
    logic [7:0]   lp_out [3];
    int           lp_count;

    logic [7:0] expected_out [$];
    byte_note_t byte_notes [$];
    logic [7:0] line_bytes [$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    int  random_sent = 0;
    int  results_checked = 0;
    int  lines_made = 0;
    bit  quiet_tail = 1'b0;

    tag_line_field_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // ------------------------------------------------------------------
    // Line parser model
    // ------------------------------------------------------------------

    task automatic emit(input logic [7:0] v);
        if (lp_count < 3)
        begin
            lp_out[lp_count] = v;
            lp_count++;
        end
    endtask

    task automatic clear_line();
        lp_phase       = PH_TAG;
        lp_delim_is_q  = 1'b0;
        lp_quoted      = 1'b0;
        lp_held_bs     = 1'b0;
        lp_file_step   = 3'd0;
        lp_value_empty = 1'b1;
        lp_skip        = 1'b0;
    endtask

    task automatic refuse_line(input tlfp_reason_t reason, input logic eol);
        emit(EV_CODE);
        lp_reason = reason;
        if (eol)
            clear_line();
        else
            lp_skip = 1'b1;
    endtask

    task automatic open_attr();
        lp_phase       = PH_NAME;
        lp_file_step   = 3'd0;
        lp_value_empty = 1'b1;
        lp_held_bs     = 1'b0;
    endtask

    // The byte right after an address whose field end has been sent.
    task automatic follow_address(input logic [7:0] b, input logic eol);
        if (eol)
        begin
            emit(EV_CODE);
            clear_line();
        end
        else if (b == CH_TAB)
            open_attr();
        else if (b == CH_SEMI)
            lp_phase = PH_SEMI;
        else
            refuse_line(RSN_JUNK, 1'b0);
    endtask

    task automatic close_value();
        if (lp_value_empty && lp_file_step == MATCH_FULL)
            emit(EV_CODE);
        emit(EV_CODE);
    endtask

    // Works out the results that one accepted line byte causes.
    task automatic parse_byte(input logic [7:0] b);
        logic eol;
        logic handled;
        eol = (b == CH_LF) || (b == CH_NUL);
        handled = 1'b0;
        lp_count = 0;
        if (lp_skip)
        begin
            if (eol)
                clear_line();
        end
        else
        begin
            case (lp_phase)
                PH_ADDR:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        emit(b);
                        lp_phase = PH_NUM;
                    end
                    else if (b == CH_SLASH || b == CH_QMARK)
                    begin
                        emit(b);
                        lp_delim_is_q = (b == CH_QMARK);
                        lp_quoted = 1'b0;
                        lp_phase = PH_PAT;
                    end
                    else
                        refuse_line(RSN_BAD_ADDR, eol);
                end
                PH_NUM:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                        emit(b);
                    else
                    begin
                        emit(EV_CODE);
                        follow_address(b, eol);
                    end
                end
                PH_PAT:
                begin
                    if (eol)
                        refuse_line(RSN_PAT_CUT, 1'b1);
                    else if (lp_quoted)
                    begin
                        emit(b);
                        lp_quoted = 1'b0;
                    end
                    else
                    begin
                        emit(b);
                        if (b == CH_BSLASH)
                            lp_quoted = 1'b1;
                        else if (b == (lp_delim_is_q ? CH_QMARK : CH_SLASH))
                            lp_phase = PH_DELIM;
                    end
                end
                PH_DELIM:
                begin
                    if (b == CH_SEMI)
                        lp_phase = PH_DSEMI;
                    else
                    begin
                        emit(EV_CODE);
                        follow_address(b, eol);
                    end
                end
                PH_DSEMI:
                begin
                    if (b == CH_SLASH || b == CH_QMARK)
                    begin
                        emit(CH_SEMI);
                        emit(b);
                        lp_delim_is_q = (b == CH_QMARK);
                        lp_quoted = 1'b0;
                        lp_phase = PH_PAT;
                    end
                    else if (b == CH_DQUOTE)
                    begin
                        emit(EV_CODE);
                        lp_phase = PH_AFTER;
                    end
                    else
                        refuse_line(RSN_JUNK, eol);
                end
                PH_SEMI:
                begin
                    if (b == CH_DQUOTE)
                        lp_phase = PH_AFTER;
                    else
                        refuse_line(RSN_JUNK, eol);
                end
                PH_AFTER:
                begin
                    if (eol)
                    begin
                        emit(EV_CODE);
                        clear_line();
                    end
                    else if (b == CH_TAB)
                        open_attr();
                    else
                        refuse_line(RSN_JUNK, 1'b0);
                end
                PH_NAME:
                begin
                    if (eol)
                    begin
                        emit(EV_CODE);
                        emit(EV_CODE);
                        clear_line();
                    end
                    else if (b == CH_TAB)
                    begin
                        emit(EV_CODE);
                        open_attr();
                    end
                    else if (b == CH_COLON)
                    begin
                        emit(EV_CODE);
                        lp_phase = PH_VALUE;
                        lp_value_empty = 1'b1;
                        lp_held_bs = 1'b0;
                    end
                    else
                    begin
                        emit(b);
                        if (lp_file_step < MATCH_FULL && b == FILE_WORD[lp_file_step[1:0]])
                            lp_file_step = lp_file_step + 3'd1;
                        else
                            lp_file_step = MATCH_NONE;
                    end
                end
                PH_VALUE:
                begin
                    // A held backslash is either translated with this byte or
                    // sent as itself before the byte is looked at.
                    if (lp_held_bs)
                    begin
                        lp_held_bs = 1'b0;
                        handled = 1'b1;
                        if (b == CH_LOW_T)
                            emit(CH_TAB);
                        else if (b == CH_LOW_N)
                            emit(CH_LF);
                        else if (b == CH_BSLASH)
                            emit(CH_BSLASH);
                        else
                        begin
                            emit(CH_BSLASH);
                            handled = 1'b0;
                        end
                    end
                    if (!handled)
                    begin
                        if (eol)
                        begin
                            close_value();
                            emit(EV_CODE);
                            clear_line();
                        end
                        else if (b == CH_TAB)
                        begin
                            close_value();
                            open_attr();
                        end
                        else if (b == CH_BSLASH)
                        begin
                            lp_held_bs = 1'b1;
                            lp_value_empty = 1'b0;
                        end
                        else
                        begin
                            emit(b);
                            lp_value_empty = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // Tag name and file name phases.
                    if (eol)
                        refuse_line(lp_phase == PH_FILE ? RSN_FILE_CUT : RSN_TAG_CUT, 1'b1);
                    else if (b == CH_TAB)
                    begin
                        emit(EV_CODE);
                        lp_phase = (lp_phase == PH_FILE) ? PH_ADDR : PH_FILE;
                    end
                    else
                    begin
                        emit(b);
                        if (lp_phase != PH_FILE)
                            lp_phase = PH_TAG;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Prediction on input transfers, checking on output transfers
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : scoreboard
        byte_note_t note;
        logic [7:0] want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                note = byte_notes.pop_front();
                parse_byte(s_axis_tdata);
                if (note.count < 0)
                begin
                    for (int i = 0; i < lp_count; i++)
                        expected_out.push_back(lp_out[i]);
                end
                else if (note.count == 1)
                    expected_out.push_back(note.result);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("out_byte: unexpected transfer, actual 0x%02h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== want)
                    begin
                        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stalls at random, none in the final part.
    initial
    begin
        @(posedge clk iff rst_n);
        m_axis_tready <= 1'b1;
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // A printable-or-not line character, never an end of line or a tab.
    function automatic logic [7:0] text_byte(input logic [7:0] bar_a, input logic [7:0] bar_b);
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == CH_LF || b == CH_TAB || b == bar_a || b == bar_b)
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    // Bytes weighted towards the characters the parser reacts to.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = CH_TAB;
            1:       b = CH_LF;
            2:       b = CH_NUL;
            3:       b = CH_SLASH;
            4:       b = CH_QMARK;
            5:       b = CH_BSLASH;
            6:       b = CH_SEMI;
            7:       b = CH_DQUOTE;
            8:       b = CH_COLON;
            9:       b = CH_ZERO + 8'($urandom_range(0, 9));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Builds one random line; most are well formed with random content.
    task automatic make_line();
        int         pick;
        int         part;
        logic [7:0] delim;
        line_bytes.delete();
        pick = $urandom_range(0, 9);
        if (pick >= 8)
        begin
            repeat ($urandom_range(1, 8)) line_bytes.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 3)) line_bytes.push_back(text_byte(CH_TAB, CH_TAB));
            line_bytes.push_back(CH_TAB);
            repeat ($urandom_range(0, 3)) line_bytes.push_back(text_byte(CH_TAB, CH_TAB));
            line_bytes.push_back(CH_TAB);
            // Address: a line number or a chain of patterns.
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            else
            begin
                part = $urandom_range(1, 3);
                for (int c = 0; c < part; c++)
                begin
                    if (c > 0)
                        line_bytes.push_back(CH_SEMI);
                    delim = $urandom_range(0, 1) ? CH_QMARK : CH_SLASH;
                    line_bytes.push_back(delim);
                    repeat ($urandom_range(0, 3))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            line_bytes.push_back(CH_BSLASH);
                            line_bytes.push_back(text_byte(CH_TAB, CH_TAB));
                        end
                        else
                            line_bytes.push_back(text_byte(delim, CH_BSLASH));
                    end
                    line_bytes.push_back(delim);
                end
            end
            if ($urandom_range(0, 2) == 0)
            begin
                line_bytes.push_back(CH_SEMI);
                line_bytes.push_back(CH_DQUOTE);
            end
            // Attributes.
            repeat ($urandom_range(0, 3))
            begin
                line_bytes.push_back(CH_TAB);
                case ($urandom_range(0, 3))
                    0: for (int j = 0; j < 4; j++) line_bytes.push_back(FILE_WORD[j]);
                    1: for (int j = 0; j < 4; j++) line_bytes.push_back(KIND_WORD[j]);
                    default:
                        repeat ($urandom_range(0, 3))
                            line_bytes.push_back(text_byte(CH_COLON, CH_COLON));
                endcase
                if ($urandom_range(0, 3) != 0)
                begin
                    line_bytes.push_back(CH_COLON);
                    repeat ($urandom_range(0, 4))
                    begin
                        part = $urandom_range(0, 6);
                        if (part <= 3)
                            line_bytes.push_back(CH_BSLASH);
                        case (part)
                            0:       line_bytes.push_back(CH_LOW_T);
                            1:       line_bytes.push_back(CH_LOW_N);
                            2:       line_bytes.push_back(CH_BSLASH);
                            default: line_bytes.push_back(text_byte(CH_BSLASH, CH_BSLASH));
                        endcase
                    end
                    // A lone backslash just before the value ends.
                    if ($urandom_range(0, 5) == 0)
                        line_bytes.push_back(CH_BSLASH);
                end
            end
            // Now and then one byte of a good line is spoilt.
            if ($urandom_range(0, 9) == 0)
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = noise_byte();
        end
        line_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_NUL);
        lines_made++;
    endtask

    // Offers one byte and waits for its transfer; may idle beforehand.
    task automatic send_byte(input logic [7:0] b, input int count, input logic [7:0] result);
        byte_note_t note;
        note.count  = count;
        note.result = result;
        byte_notes.push_back(note);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    initial
    begin : main
        dir_row_t rows [];
        rows = '{
            '{CH_NUL,    1,  EV_CODE},   // line cut off in the tag name
            '{8'hFF,     1,  8'hFF},
            '{CH_TAB,    -1, 8'h00},
            '{CH_LF,     1,  EV_CODE},   // line cut off in the file name
            '{CH_TAB,    -1, 8'h00},     // empty tag and file names
            '{CH_TAB,    -1, 8'h00},
            '{"x",       1,  EV_CODE},   // address starting badly
            '{"y",       0,  8'h00},     // ignored up to the end of line
            '{CH_LF,     0,  8'h00},
            '{CH_TAB,    -1, 8'h00},
            '{CH_TAB,    -1, 8'h00},
            '{CH_QMARK,  -1, 8'h00},
            '{CH_BSLASH, -1, 8'h00},     // quoted delimiter
            '{CH_QMARK,  -1, 8'h00},
            '{CH_QMARK,  -1, 8'h00},
            '{CH_SEMI,   -1, 8'h00},     // pattern chain
            '{CH_SLASH,  -1, 8'h00},
            '{CH_LF,     1,  EV_CODE},   // pattern cut off
            '{CH_TAB,    -1, 8'h00},
            '{CH_TAB,    -1, 8'h00},
            '{"7",       -1, 8'h00},
            '{CH_SEMI,   -1, 8'h00},     // trailing ;" after a line number
            '{CH_DQUOTE, -1, 8'h00},
            '{CH_TAB,    -1, 8'h00},
            '{"f",       -1, 8'h00},
            '{"i",       -1, 8'h00},
            '{"l",       -1, 8'h00},
            '{"e",       -1, 8'h00},
            '{CH_COLON,  -1, 8'h00},
            '{CH_TAB,    -1, 8'h00},     // empty value of the file attribute
            '{"k",       -1, 8'h00},
            '{CH_COLON,  -1, 8'h00},
            '{CH_BSLASH, -1, 8'h00},
            '{"q",       -1, 8'h00},     // backslash before an ordinary byte
            '{CH_BSLASH, -1, 8'h00},
            '{CH_LF,     -1, 8'h00}      // backslash at the line end
        };

        clear_line();
        lp_reason = RSN_NONE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (rows[i])
            send_byte(rows[i].data, rows[i].count, rows[i].result);

        // Random lines until enough bytes have gone in.
        while (random_sent < RANDOM_ITEMS)
        begin
            make_line();
            foreach (line_bytes[i])
            begin
                send_byte(line_bytes[i], -1, 8'h00);
                random_sent++;
                if (random_sent > QUIET_AFTER)
                    quiet_tail = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then keep watching the output for anything stray.
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d line bytes (%0d random lines) and checked %0d results.",
                 bytes_sent, lines_made, results_checked);
        $display("Covered rejects, pattern chains, escapes and empty file values.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
